>>> hdl/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
// Holds the transfer payload structs, parse phase and base codes, character codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ilp_pkg;

    localparam int VALUE_BITS_DEFAULT = 64;
    localparam int OUT_VALUE_W        = 64;

    // Parse phase codes
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_STOP   = 3'd4;

    // Base codes
    localparam logic [1:0] BC_DEC = 2'd0;
    localparam logic [1:0] BC_BIN = 2'd1;
    localparam logic [1:0] BC_OCT = 2'd2;
    localparam logic [1:0] BC_HEX = 2'd3;

    // Character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] value;
        logic                          range_error;
    } out_item_t;

    // Control part of the parse state
    typedef struct packed {
        logic [2:0] parse_phase;
        logic       negative_flag;
        logic [1:0] base_code;
        logic       overflow_flag;
    } parse_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/ilp_step.sv
// Next-state logic for one character of the literal: sign, prefix, digit accumulation.
// Depends on ilp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilp_step #(
    parameter int VALUE_BITS = ilp_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic [7:0]            char_code,
    input  wire ilp_pkg::parse_ctrl_t  ctrl,
    input  wire logic [VALUE_BITS-2:0] magnitude,
    output ilp_pkg::parse_ctrl_t       ctrl_next,
    output logic      [VALUE_BITS-2:0] magnitude_next
);
    import ilp_pkg::*;

    localparam int MAG_W  = VALUE_BITS - 1;
    localparam int WIDE_W = MAG_W + 5;

    logic [3:0]        digit;
    logic              is_digit;
    logic              digit_ok;
    logic [WIDE_W-1:0] mag_w;
    logic [WIDE_W-1:0] scaled;
    logic [WIDE_W-1:0] acc;
    logic [WIDE_W-1:0] lim_w;
    logic              take_ovf;

    // Digit value, any base
    always_comb
    begin
        digit    = 4'd0;
        is_digit = 1'b0;
        if (char_code >= CH_ZERO && char_code <= CH_NINE)
        begin
            digit    = 4'(char_code - CH_ZERO);
            is_digit = 1'b1;
        end
        else if (char_code >= CH_LC_A && char_code <= CH_LC_F)
        begin
            digit    = 4'(char_code - CH_LC_A + 8'd10);
            is_digit = 1'b1;
        end
        else if (char_code >= CH_UC_A && char_code <= CH_UC_F)
        begin
            digit    = 4'(char_code - CH_UC_A + 8'd10);
            is_digit = 1'b1;
        end
    end

    // Scale by the base with shifts and a single add
    always_comb
    begin
        mag_w = WIDE_W'(magnitude);
        case (ctrl.base_code)
            BC_BIN:  begin scaled = mag_w << 1; digit_ok = is_digit && digit < 4'd2;  end
            BC_OCT:  begin scaled = mag_w << 3; digit_ok = is_digit && digit < 4'd8;  end
            BC_HEX:  begin scaled = mag_w << 4; digit_ok = is_digit;                  end
            default: begin scaled = (mag_w << 3) + (mag_w << 1);
                           digit_ok = is_digit && digit < 4'd10; end
        endcase
        lim_w    = WIDE_W'({MAG_W{1'b1}});
        acc      = scaled + WIDE_W'(digit);
        take_ovf = acc > lim_w;
    end

    always_comb
    begin
        ctrl_next      = ctrl;
        magnitude_next = magnitude;
        case (ctrl.parse_phase)
            PH_START, PH_SIGN, PH_ZERO, PH_DIGITS:
            begin
                if (ctrl.parse_phase == PH_START && char_code == CH_MINUS)
                begin
                    ctrl_next.negative_flag = 1'b1;
                    ctrl_next.parse_phase   = PH_SIGN;
                end
                else if (ctrl.parse_phase == PH_START && char_code == CH_PLUS)
                begin
                    ctrl_next.parse_phase = PH_SIGN;
                end
                else if ((ctrl.parse_phase == PH_START || ctrl.parse_phase == PH_SIGN)
                         && char_code == CH_ZERO)
                begin
                    ctrl_next.parse_phase = PH_ZERO;
                end
                else if (ctrl.parse_phase == PH_ZERO && char_code == CH_LC_B)
                begin
                    ctrl_next.base_code   = BC_BIN;
                    ctrl_next.parse_phase = PH_DIGITS;
                end
                else if (ctrl.parse_phase == PH_ZERO && char_code == CH_LC_O)
                begin
                    ctrl_next.base_code   = BC_OCT;
                    ctrl_next.parse_phase = PH_DIGITS;
                end
                else if (ctrl.parse_phase == PH_ZERO && char_code == CH_LC_X)
                begin
                    ctrl_next.base_code   = BC_HEX;
                    ctrl_next.parse_phase = PH_DIGITS;
                end
                else if (!digit_ok)
                begin
                    ctrl_next.parse_phase = PH_STOP;
                end
                else
                begin
                    ctrl_next.parse_phase = PH_DIGITS;
                    if (!ctrl.overflow_flag)
                    begin
                        if (take_ovf)
                        begin
                            ctrl_next.overflow_flag = 1'b1;
                            magnitude_next          = {MAG_W{1'b1}};
                        end
                        else
                        begin
                            magnitude_next = acc[MAG_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                ctrl_next.parse_phase = PH_STOP;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/integer_literal_parser_top.sv
// Top level of the integer literal parser: parse state, result register, handshakes.
// Depends on ilp_pkg and ilp_step.
//
// Usage:
//   Characters of one literal arrive on the char channel, one per transfer,
//   with last_char set on the final one. An optional '-' or '+' comes first,
//   then an optional 0b / 0o / 0x prefix; decimal otherwise. Digits valid for
//   the base accumulate until the first invalid character, after which the
//   rest of the literal is ignored.
//   The transfer of a last character loads one result into the output
//   register: the signed value (sign applied after saturation, sign-extended
//   to 64 bits) and range_error when the magnitude passed 2^(VALUE_BITS-1)-1.
//   The result is registered: it is valid in the cycle after the last character transfer.
//   Throughput: one character per cycle while char_ready is high, as the
//   combinational next-state logic of ilp_step feeds the parse state registers.
//   Stall: while a result waits and res_ready is low, char_ready drops; it
//   stays high whenever the output register is empty or being drained.
//   Reset: clears the parse state to start of literal and empties the result
//   register.
`timescale 1ns / 1ps
`default_nettype none

module integer_literal_parser_top #(
    parameter int VALUE_BITS = ilp_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_ready,
    input  wire ilp_pkg::in_item_t  char_item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output ilp_pkg::out_item_t      res_item
);
    import ilp_pkg::*;

    localparam int MAG_W = VALUE_BITS - 1;

    localparam parse_ctrl_t CTRL_CLEAR = '{
        parse_phase:   PH_START,
        negative_flag: 1'b0,
        base_code:     BC_DEC,
        overflow_flag: 1'b0
    };

    parse_ctrl_t              ctrl_reg;
    parse_ctrl_t              ctrl_next;
    logic        [MAG_W-1:0]  mag_reg;
    logic        [MAG_W-1:0]  mag_next;
    logic                     res_valid_reg;
    out_item_t                res_item_reg;
    logic                     char_xfer;
    logic signed [VALUE_BITS-1:0] value_s;

    // Accept a character whenever the output register is free or draining
    assign char_ready = !res_valid_reg || res_ready;
    assign char_xfer  = char_valid && char_ready;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;

    ilp_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .char_code      (char_item.char_code),
        .ctrl           (ctrl_reg),
        .magnitude      (mag_reg),
        .ctrl_next      (ctrl_next),
        .magnitude_next (mag_next)
    );

    // Apply the sign to the saturated magnitude
    assign value_s = ctrl_next.negative_flag ? -$signed({1'b0, mag_next})
                                             :  $signed({1'b0, mag_next});

    // Parse state: advance on each transfer, clear after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= CTRL_CLEAR;
            mag_reg  <= '0;
        end
        else if (char_xfer)
        begin
            if (char_item.last_char)
            begin
                ctrl_reg <= CTRL_CLEAR;
                mag_reg  <= '0;
            end
            else
            begin
                ctrl_reg <= ctrl_next;
                mag_reg  <= mag_next;
            end
        end
    end

    // Result register valid flag: load on last character, drop on drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (char_xfer && char_item.last_char)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload: hold until the next last character
    always_ff @(posedge clk)
    begin
        if (char_xfer && char_item.last_char)
        begin
            res_item_reg.value       <= OUT_VALUE_W'(value_s);
            res_item_reg.range_error <= ctrl_next.overflow_flag;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/integer_literal_parser_top_tb.sv
// Self-checking testbench for integer_literal_parser_top: streams literals one character
// per transfer and checks every result against an in-bench model of the parser.
// Depends on ilp_pkg and the RTL of integer_literal_parser_top.
`timescale 1ns / 1ps

module integer_literal_parser_top_tb;
    import ilp_pkg::*;

    localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
    localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
    localparam logic [63:0] NOT_A_DIGIT = 64'd99;
    // No transfer on either channel for this many cycles means the block has hung.
    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_CHARS = 830;

    // One queued character, with a flag that holds the sender until all results are in.
    typedef struct packed {
        logic     drain_first;
        in_item_t item;
    } queued_char_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_ready;
    in_item_t  char_item = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_item_t res_item;

    integer_literal_parser_top #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    // Characters waiting to be sent, and results predicted but not yet seen.
    queued_char_t char_queue[$];
    out_item_t    expected_literals[$];

    // Model copy of the parse state.
    logic [2:0]  lit_phase;
    logic        lit_negative;
    logic [1:0]  lit_base;
    logic [63:0] lit_magnitude;
    logic        lit_overflow;

    int error_count = 0;
    int literals_queued = 0;
    int chars_sent = 0;
    int results_checked = 0;
    int range_errors_seen = 0;
    int negatives_seen = 0;
    int drain_pauses = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------
    // Clock: 20 ns period.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Model of the parser.
    // ------------------------------------------------------------------
    function automatic logic [63:0] radix_of(logic [1:0] code);
        case (code)
            BC_BIN:  return 64'd2;
            BC_OCT:  return 64'd8;
            BC_HEX:  return 64'd16;
            default: return 64'd10;
        endcase
    endfunction

    // Digit value in any base; both letter cases count for hex.
    function automatic logic [63:0] digit_of(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 64'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F)
            return 64'(c - CH_LC_A) + 64'd10;
        if (c >= CH_UC_A && c <= CH_UC_F)
            return 64'(c - CH_UC_A) + 64'd10;
        return NOT_A_DIGIT;
    endfunction

    task automatic clear_literal();
        lit_phase     = PH_START;
        lit_negative  = 1'b0;
        lit_base      = BC_DEC;
        lit_magnitude = '0;
        lit_overflow  = 1'b0;
    endtask

    // Accumulate one digit, saturating at the magnitude bound; stop on a character that is not a digit of the base.
    task automatic accumulate_digit(logic [7:0] c);
        logic [63:0] d;
        logic [63:0] b;
        d = digit_of(c);
        b = radix_of(lit_base);
        if (d >= b)
        begin
            lit_phase = PH_STOP;
            return;
        end
        lit_phase = PH_DIGITS;
        if (lit_overflow)
            return;
        if (lit_magnitude > (MAG_LIMIT - d) / b)
        begin
            lit_overflow  = 1'b1;
            lit_magnitude = MAG_LIMIT;
        end
        else
            lit_magnitude = lit_magnitude * b + d;
    endtask

    // Advance the model by one accepted character; a last character yields a result.
    task automatic advance_parse(in_item_t it);
        logic [63:0] raw;
        out_item_t   res;
        case (lit_phase)
            PH_START:
            begin
                if (it.char_code == CH_MINUS)
                begin
                    lit_negative = 1'b1;
                    lit_phase    = PH_SIGN;
                end
                else if (it.char_code == CH_PLUS)
                    lit_phase = PH_SIGN;
                else if (it.char_code == CH_ZERO)
                    lit_phase = PH_ZERO;
                else
                    accumulate_digit(it.char_code);
            end
            PH_SIGN:
            begin
                if (it.char_code == CH_ZERO)
                    lit_phase = PH_ZERO;
                else
                    accumulate_digit(it.char_code);
            end
            PH_ZERO:
            begin
                if (it.char_code == CH_LC_B)
                begin
                    lit_base  = BC_BIN;
                    lit_phase = PH_DIGITS;
                end
                else if (it.char_code == CH_LC_O)
                begin
                    lit_base  = BC_OCT;
                    lit_phase = PH_DIGITS;
                end
                else if (it.char_code == CH_LC_X)
                begin
                    lit_base  = BC_HEX;
                    lit_phase = PH_DIGITS;
                end
                else
                begin
                    lit_base = BC_DEC;
                    accumulate_digit(it.char_code);
                end
            end
            PH_DIGITS:
                accumulate_digit(it.char_code);
            default:
                lit_phase = PH_STOP;
        endcase
        if (!it.last_char)
            return;
        raw = lit_negative ? (64'd0 - lit_magnitude) : lit_magnitude;
        // Sign-extend from VALUE_BITS to the 64-bit port.
        res.value       = $signed(raw << (64 - VALUE_BITS)) >>> (64 - VALUE_BITS);
        res.range_error = lit_overflow;
        expected_literals.push_back(res);
        clear_literal();
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("[%0t] MISMATCH %s: expected 0x%016h, got 0x%016h", $time, what, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    task automatic add_char(logic [7:0] c, logic last, logic drain_first = 1'b0);
        queued_char_t q;
        q.drain_first    = drain_first;
        q.item.char_code = c;
        q.item.last_char = last;
        char_queue.push_back(q);
        if (last)
            literals_queued++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] random_digit(logic [1:0] code);
        int d;
        d = $urandom_range(0, int'(radix_of(code)) - 1);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(d - 10);
    endfunction

    // A character that ends accumulation in any base.
    function automatic logic [7:0] random_breaker();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h20;
            2:       return CH_MINUS;
            3:       return CH_PLUS;
            4:       return 8'($urandom_range(128, 255));
            default: return 8'h67;
        endcase
    endfunction

    // Mostly well-formed literals with random content; some noise and broken ones.
    task automatic add_random_literal(logic drain_first);
        logic [7:0] lit[$];
        logic [1:0] code;
        int         kind;
        int         ndigits;
        int         max_digits;
        string      near_max;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // Pure noise over the whole character range.
            repeat ($urandom_range(1, 6))
                lit.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: lit.push_back(CH_MINUS);
                1: lit.push_back(CH_PLUS);
                default: ;
            endcase
            code = 2'($urandom_range(0, 3));
            if (code != BC_DEC)
            begin
                lit.push_back(CH_ZERO);
                case (code)
                    BC_BIN:  lit.push_back(CH_LC_B);
                    BC_OCT:  lit.push_back(CH_LC_O);
                    default: lit.push_back(CH_LC_X);
                endcase
                // Occasionally an upper-case prefix letter, which does not select a base.
                if ($urandom_range(0, 29) == 0)
                    lit[lit.size() - 1] = lit[lit.size() - 1] - 8'h20;
            end
            else if ($urandom_range(0, 9) == 0)
                lit.push_back(CH_ZERO);
            case (code)
                BC_BIN:  max_digits = VALUE_BITS - 1;
                BC_OCT:  max_digits = (VALUE_BITS + 1) / 3;
                BC_HEX:  max_digits = VALUE_BITS / 4;
                default: max_digits = 19;
            endcase
            kind = $urandom_range(0, 99);
            if (kind < 70)
                ndigits = $urandom_range(1, 6);
            else if (kind < 85)
                ndigits = $urandom_range(0, 12);
            else if (kind < 95 || code != BC_DEC)
                ndigits = $urandom_range(max_digits - 1, max_digits + 1);
            else
                ndigits = -1;
            if (ndigits < 0)
            begin
                // Straddle the decimal bound digit by digit.
                near_max = "922337203685477580";
                for (int i = 0; i < near_max.len(); i++)
                    lit.push_back(near_max[i]);
                lit.push_back(random_digit(BC_DEC));
            end
            else
            begin
                for (int i = 0; i < ndigits; i++)
                    lit.push_back(random_digit(code));
                // Bias the leading digit high so that long runs do reach the bound.
                if (ndigits >= max_digits - 1 && $urandom_range(0, 1))
                    lit[lit.size() - ndigits] = (code == BC_HEX) ? CH_LC_F :
                                               CH_ZERO + 8'(int'(radix_of(code)) - 1);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                lit.push_back(random_breaker());
                repeat ($urandom_range(0, 3))
                    lit.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (lit.size() == 0)
            lit.push_back(random_digit(BC_DEC));
        foreach (lit[i])
            add_char(lit[i], i == lit.size() - 1, drain_first && i == 0);
    endtask

    // ------------------------------------------------------------------
    // Character driver: bursts of random length with random gaps. Valid is
    // held with a stable payload until the transfer; the model advances on
    // every accepted character.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin : char_driver
        logic        valid_next;
        logic        slot_free;
        logic        hold_for_drain;
        queued_char_t head;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            clear_literal();
        end
        else
        begin
            valid_next = char_valid;
            slot_free  = !char_valid || char_ready;
            if (char_valid && char_ready)
            begin
                advance_parse(char_item);
                chars_sent++;
            end
            if (slot_free)
            begin
                valid_next = 1'b0;
                hold_for_drain = 1'b0;
                if (char_queue.size() != 0)
                    hold_for_drain = char_queue[0].drain_first &&
                                     expected_literals.size() != 0;
                if (gap_left > 0)
                    gap_left--;
                else if (char_queue.size() != 0 && !hold_for_drain)
                begin
                    head = char_queue.pop_front();
                    if (head.drain_first)
                        drain_pauses++;
                    char_item  <= head.item;
                    valid_next = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = 1;
                            2:       gap_left = $urandom_range(1, 3);
                            default: gap_left = $urandom_range(4, 8);
                        endcase
                    end
                end
            end
            char_valid <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each transfer against the oldest prediction and
    // drive res_ready on a stall pattern whose mode is redrawn at random as pattern_cycle advances.
    // ------------------------------------------------------------------
    int pattern_cycle = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        logic      ready_next;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_literals.size() == 0)
                    report_mismatch("result with nothing expected", '0, res_item.value);
                else
                begin
                    want = expected_literals.pop_front();
                    if (res_item.value !== want.value)
                        report_mismatch("value", want.value, res_item.value);
                    if (res_item.range_error !== want.range_error)
                        report_mismatch("range_error", 64'(want.range_error),
                                        64'(res_item.range_error));
                    results_checked++;
                    if (want.range_error)
                        range_errors_seen++;
                    if (want.value < 0)
                        negatives_seen++;
                end
            end
            pattern_cycle++;
            if (pattern_cycle % 48 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: ready_next = 1'b1;
                1: ready_next = 1'($urandom_range(0, 1));
                2: ready_next = (pattern_cycle % 5) != 0;
                default:
                begin
                    // Long stalls, with a random length drawn into stall_left.
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        ready_next = 1'b0;
                    end
                    else
                    begin
                        ready_next = 1'b1;
                        if ($urandom_range(0, 2) == 0)
                            stall_left = $urandom_range(1, 10);
                    end
                end
            endcase
            res_ready <= ready_next;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles without any transfer; stop the run at the limit.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && char_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, wait for drain, report.
    // ------------------------------------------------------------------
    initial
    begin
        int directed_chars;
        clear_literal();

        // Directed literals: zero forms, each base, both hex letter cases,
        // prefixes that select nothing, empty digit runs and the 64-bit bounds.
        add_text("0");
        add_text("-0");
        add_text("+9");
        add_text("012");
        add_text("0b101");
        add_text("-0o17");
        add_text("0xAf");
        add_text("0X1");
        add_text("0x");
        add_text("-");
        add_text("0xg");
        add_text("1 2");
        add_text("-+5");
        add_text("9223372036854775807");
        add_text("-9223372036854775808");
        add_text("99999999999999999999");
        add_text("0x7fffffffffffffff");
        add_char(8'h00, 1'b1);
        add_char(8'h37, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(8'h35, 1'b1);
        directed_chars = char_queue.size();

        // Random part; hold the sender for a full drain now and then.
        while (char_queue.size() < directed_chars + RANDOM_CHARS)
            add_random_literal(char_queue.size() == directed_chars ||
                               $urandom_range(0, 39) == 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || char_valid || expected_literals.size() != 0)
            @(posedge clk);
        // The result is registered in the cycle after the last character; allow a margin.
        repeat (8) @(posedge clk);

        if (expected_literals.size() != 0)
        begin
            $display("[%0t] %0d expected results never arrived", $time,
                     expected_literals.size());
            error_count++;
        end

        $display("Run covered %0d characters in %0d literals, %0d results checked",
                 chars_sent, literals_queued, results_checked);
        $display("  of which %0d negative and %0d saturated; %0d drain pauses, %0d mismatches",
                 negatives_seen, range_errors_seen, drain_pauses, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
